// ===== rtl/cleb_pkg.sv =====
`timescale 1ns / 1ps
package cleb_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FIELD_W  = 7;

  localparam logic [2:0] ACT_LEFT   = 3'd0;
  localparam logic [2:0] ACT_RIGHT  = 3'd1;
  localparam logic [2:0] ACT_ERASE  = 3'd2;
  localparam logic [2:0] ACT_INSERT = 3'd3;
  localparam logic [2:0] ACT_DUMP   = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BOUNDARY = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_RESULT,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic move_rd;
    logic move_wr;
    logic edit_wr;
    logic dump_start;
    logic dump_rd;
    logic dump_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       before_zero;
    logic       after_zero;
    logic       total_zero;
    logic       dump_last;
    logic       out_free;
  } stat_t;

endpackage

// ===== rtl/cleb_ctrl.sv =====
`timescale 1ns / 1ps
module cleb_ctrl
  import cleb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.act)
          ACT_LEFT:  state_next = stat.before_zero ? S_RESULT : S_MOVE;
          ACT_RIGHT: state_next = stat.after_zero ? S_RESULT : S_MOVE;
          ACT_DUMP:  state_next = stat.total_zero ? S_RESULT : S_DUMP_RD;
          default:   state_next = S_RESULT;
        endcase
      end
      S_MOVE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat.out_free) state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_EXEC: begin
        cmd.move_rd    = ((stat.act == ACT_LEFT) && !stat.before_zero) ||
                         ((stat.act == ACT_RIGHT) && !stat.after_zero);
        cmd.dump_start = (stat.act == ACT_DUMP) && !stat.total_zero;
      end
      S_MOVE: begin
        cmd.move_wr = stat.out_free;
      end
      S_RESULT: begin
        cmd.edit_wr = stat.out_free;
      end
      S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
      end
      S_DUMP_OUT: begin
        cmd.dump_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/cleb_dp.sv =====
`timescale 1ns / 1ps
module cleb_dp
  import cleb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [2:0]         action,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               last,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] length,
  output logic [FIELD_W-1:0] cursor_pos
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [7:0]       mem [CAPACITY];
  logic [7:0]       rdata;
  logic [2:0]       act;
  logic [7:0]       ch;
  logic [CNT_W-1:0] before_count;
  logic [CNT_W-1:0] before_next;
  logic [CNT_W-1:0] after_count;
  logic [CNT_W-1:0] after_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] total;
  logic             full;
  logic             out_free;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] dump_addr;
  logic             we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]       wd;
  logic             out_load;
  logic [1:0]       edit_status;

  assign total     = before_count + after_count;
  assign full      = (total >= CAP_C);
  assign out_free  = !out_valid || !out_stall;
  assign dump_addr = (idx < before_count) ? ADDR_W'(idx) : ADDR_W'(idx + CAP_C - total);

  assign stat.act         = act;
  assign stat.before_zero = (before_count == '0);
  assign stat.after_zero  = (after_count == '0);
  assign stat.total_zero  = (total == '0);
  assign stat.dump_last   = ((idx + ONE_C) == total);
  assign stat.out_free    = out_free;

  always_comb begin
    rd_en   = cmd.move_rd || cmd.dump_rd;
    rd_addr = dump_addr;
    if (cmd.move_rd) begin
      rd_addr = (act == ACT_LEFT) ? ADDR_W'(before_count - ONE_C)
                                  : ADDR_W'(CAP_C - after_count);
    end
  end

  always_comb begin
    we = cmd.move_wr || (cmd.edit_wr && (act == ACT_INSERT) && !full);
    wd = cmd.move_wr ? rdata : ch;
    wa = ADDR_W'(before_count);
    if (cmd.move_wr && (act == ACT_LEFT)) begin
      wa = ADDR_W'(CAP_C - after_count - ONE_C);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    before_next = before_count;
    after_next  = after_count;
    edit_status = ST_DONE;
    if (cmd.move_wr) begin
      if (act == ACT_LEFT) begin
        before_next = before_count - ONE_C;
        after_next  = after_count + ONE_C;
      end else begin
        before_next = before_count + ONE_C;
        after_next  = after_count - ONE_C;
      end
    end
    unique case (act)
      ACT_LEFT, ACT_RIGHT: begin
        edit_status = ST_BOUNDARY;
      end
      ACT_ERASE: begin
        if (before_count == '0) begin
          edit_status = ST_BOUNDARY;
        end else if (cmd.edit_wr) begin
          before_next = before_count - ONE_C;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          edit_status = ST_FULL;
        end else if (cmd.edit_wr) begin
          before_next = before_count + ONE_C;
        end
      end
      ACT_DUMP: begin
        edit_status = ST_EMPTY;
      end
      default: begin
        edit_status = ST_DONE;
      end
    endcase
  end

  assign out_load = cmd.move_wr || cmd.edit_wr || cmd.dump_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      before_count <= '0;
      after_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      before_count <= before_next;
      after_count  <= after_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act <= action;
      ch  <= character;
    end
    if (cmd.dump_start) begin
      idx <= '0;
    end else if (cmd.dump_out) begin
      idx <= idx + ONE_C;
    end
    if (out_load) begin
      out_char   <= cmd.dump_out ? rdata : 8'd0;
      last       <= cmd.dump_out ? stat.dump_last : 1'b1;
      status     <= (cmd.edit_wr) ? edit_status : ST_DONE;
      length     <= FIELD_W'(before_next + after_next);
      cursor_pos <= FIELD_W'(before_next);
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (total <= CAP_C))
    else $error("text length exceeds capacity");

  a_move_keeps_total: assert property (@(posedge clk) disable iff (rst)
    cmd.move_wr |=> (total == $past(total)))
    else $error("cursor move changed text length");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.edit_wr && (act == ACT_INSERT) && !full) |=>
      (before_count == $past(before_count) + ONE_C))
    else $error("insert did not advance cursor");

  a_dump_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_out |-> (idx < total))
    else $error("dump index beyond text");

endmodule

// ===== rtl/cursor_line_edit_buffer_top.sv =====
`timescale 1ns / 1ps
// Every edit, a cursor move included, passes the execute state and then the move or result
// state, which loads its result into the output registers once the output side is free.
// A dump of n characters reads each one from memory in a registered read state and loads
// it in the output state once the output side is free, then reads the next character.
// A new item is taken only after the previous item's last result is loaded.
// Synchronous active-high reset empties the text and puts the cursor at zero.
module cursor_line_edit_buffer_top
  import cleb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [7:0]         character,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               last,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] length,
  output logic [FIELD_W-1:0] cursor_pos
);

  cmd_t  cmd;
  stat_t stat;

  cleb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cleb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .character  (character),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .last       (last),
    .status     (status),
    .length     (length),
    .cursor_pos (cursor_pos)
  );

endmodule

// ===== bench/tb_cursor_line_edit_buffer_top.sv =====
`timescale 1ns / 1ps
module tb_cursor_line_edit_buffer_top;
  import cleb_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int RANDOM_ITEMS    = 300;
  localparam int HOLD_OFF_AT     = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;

  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_B = 3'd6;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;

  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic [1:0]         status;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] cursor;
  } line_result_t;

  typedef struct {
    logic [2:0]   act;
    logic [7:0]   ch;
    bit           typed;
    line_result_t want;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         action = ACT_LEFT;
  logic [7:0]         character = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_char;
  logic               last;
  logic [1:0]         status;
  logic [FIELD_W-1:0] length;
  logic [FIELD_W-1:0] cursor_pos;

  logic [7:0]   text_mem [CAPACITY];
  int           left_len = 0;
  int           right_len = 0;
  line_result_t expected_q [$];
  script_row_t  script [$];
  int           errors = 0;
  int           tx_count = 0;
  int           rx_count = 0;
  int           cycles = 0;

  cursor_line_edit_buffer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .character  (character),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .last       (last),
    .status     (status),
    .length     (length),
    .cursor_pos (cursor_pos)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_result(input logic [7:0] ch, input logic fin,
                                      input logic [1:0] st);
    line_result_t r;
    r.ch     = ch;
    r.last   = fin;
    r.status = st;
    r.length = FIELD_W'(left_len + right_len);
    r.cursor = FIELD_W'(left_len);
    expected_q.push_back(r);
  endfunction

  function automatic void apply_action(input logic [2:0] act, input logic [7:0] ch);
    logic [1:0] st;
    int         total;
    int         i;
    int         idx;
    st    = ST_DONE;
    total = left_len + right_len;
    case (act)
      ACT_LEFT: begin
        if (left_len == 0) begin
          st = ST_BOUNDARY;
        end else begin
          text_mem[CAPACITY - right_len - 1] = text_mem[left_len - 1];
          left_len--;
          right_len++;
        end
      end
      ACT_RIGHT: begin
        if (right_len == 0) begin
          st = ST_BOUNDARY;
        end else begin
          text_mem[left_len] = text_mem[CAPACITY - right_len];
          left_len++;
          right_len--;
        end
      end
      ACT_ERASE: begin
        if (left_len == 0) st = ST_BOUNDARY;
        else left_len--;
      end
      ACT_INSERT: begin
        if (total >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          text_mem[left_len] = ch;
          left_len++;
        end
      end
      ACT_DUMP: begin
        if (total == 0) begin
          push_result(8'h00, 1'b1, ST_EMPTY);
        end else begin
          for (i = 0; i < total; i++) begin
            idx = (i < left_len) ? i : CAPACITY - right_len + (i - left_len);
            push_result(text_mem[idx], i == total - 1, ST_DONE);
          end
        end
        return;
      end
      default: ;
    endcase
    push_result(8'h00, 1'b1, st);
  endfunction

  function automatic script_row_t typed_row(input logic [2:0] act, input logic [7:0] ch,
                                            input logic [1:0] st, input int len,
                                            input int cur);
    script_row_t row;
    row.act         = act;
    row.ch          = ch;
    row.typed       = 1'b1;
    row.want.ch     = 8'h00;
    row.want.last   = 1'b1;
    row.want.status = st;
    row.want.length = FIELD_W'(len);
    row.want.cursor = FIELD_W'(cur);
    return row;
  endfunction

  function automatic script_row_t open_row(input logic [2:0] act, input logic [7:0] ch);
    script_row_t row;
    row.act   = act;
    row.ch    = ch;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_INSERT;
    if (r < 55) return ACT_LEFT;
    if (r < 70) return ACT_RIGHT;
    if (r < 86) return ACT_ERASE;
    if (r < 93) return ACT_DUMP;
    return ACT_RSVD_A + 3'($urandom_range(0, 2));
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic transfer_item(input logic [2:0] act, input logic [7:0] ch);
    int gap;
    gap = ((tx_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    character <= ch;
    do @(posedge clk); while (in_stall);
    tx_count++;
    apply_action(act, ch);
  endtask

  initial begin
    int k;
    int ep;
    int fills;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_LEFT;
    character <= 8'h00;

    script.push_back(typed_row(ACT_LEFT,   8'h00, ST_BOUNDARY, 0, 0));
    script.push_back(typed_row(ACT_RIGHT,  8'h00, ST_BOUNDARY, 0, 0));
    script.push_back(typed_row(ACT_ERASE,  8'h00, ST_BOUNDARY, 0, 0));
    script.push_back(typed_row(ACT_DUMP,   8'h00, ST_EMPTY,    0, 0));
    script.push_back(typed_row(ACT_RSVD_A, 8'hFF, ST_DONE,     0, 0));
    script.push_back(typed_row(ACT_INSERT, 8'h00, ST_DONE,     1, 1));
    script.push_back(typed_row(ACT_INSERT, 8'hFF, ST_DONE,     2, 2));
    script.push_back(typed_row(ACT_LEFT,   8'h00, ST_DONE,     2, 1));
    script.push_back(open_row(ACT_DUMP,    8'h00));
    script.push_back(typed_row(ACT_LEFT,   8'h00, ST_DONE,     2, 0));
    script.push_back(typed_row(ACT_LEFT,   8'h00, ST_BOUNDARY, 2, 0));
    script.push_back(typed_row(ACT_ERASE,  8'h00, ST_BOUNDARY, 2, 0));
    script.push_back(typed_row(ACT_RIGHT,  8'h00, ST_DONE,     2, 1));
    script.push_back(typed_row(ACT_RIGHT,  8'h00, ST_DONE,     2, 2));
    script.push_back(typed_row(ACT_RIGHT,  8'h00, ST_BOUNDARY, 2, 2));
    script.push_back(typed_row(ACT_INSERT, 8'hA5, ST_DONE,     3, 3));
    script.push_back(typed_row(ACT_LEFT,   8'h00, ST_DONE,     3, 2));
    script.push_back(typed_row(ACT_ERASE,  8'h00, ST_DONE,     2, 1));
    script.push_back(open_row(ACT_INSERT,  8'h5A));
    script.push_back(open_row(ACT_RSVD_B,  8'h81));
    script.push_back(open_row(ACT_RSVD_C,  8'h7E));
    script.push_back(open_row(ACT_DUMP,    8'h00));
    script.push_back(open_row(ACT_ERASE,   8'h00));
    script.push_back(open_row(ACT_ERASE,   8'h00));
    script.push_back(open_row(ACT_RIGHT,   8'h00));
    script.push_back(typed_row(ACT_ERASE,  8'h00, ST_DONE,     0, 0));
    script.push_back(typed_row(ACT_DUMP,   8'h00, ST_EMPTY,    0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      transfer_item(script[i].act, script[i].ch);
      if (script[i].typed) begin
        expected_q.delete(expected_q.size() - 1);
        expected_q.push_back(script[i].want);
      end
    end

    fills = 0;
    while (tx_count < script.size() + RANDOM_ITEMS) begin
      if (fills < 2 && tx_count >= script.size() + 80 + 160 * fills) begin
        while (left_len + right_len < CAPACITY) transfer_item(ACT_INSERT, 8'($urandom));
        repeat ($urandom_range(1, 3)) transfer_item(ACT_INSERT, 8'($urandom));
        transfer_item(ACT_DUMP, 8'($urandom));
        fills++;
      end else begin
        ep = $urandom_range(0, 5);
        if (ep == 0) begin
          k = $urandom_range(1, 16);
          repeat (k) transfer_item(ACT_LEFT, 8'($urandom));
          transfer_item(ACT_DUMP, 8'($urandom));
          k = $urandom_range(1, 16);
          repeat (k) transfer_item(ACT_RIGHT, 8'($urandom));
        end else if (ep == 1) begin
          k = $urandom_range(0, 1) ? $urandom_range(1, 8) : left_len + $urandom_range(1, 2);
          repeat (k) transfer_item(ACT_ERASE, 8'($urandom));
          transfer_item(ACT_DUMP, 8'($urandom));
        end else begin
          repeat (8) transfer_item(pick_action(), 8'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int           hold;
    line_result_t want;
    wait (!rst);
    forever begin
      // One long hold-off lets the block back up and stall its input side.
      if (rx_count == HOLD_OFF_AT) hold = HOLD_OFF_CYCLES;
      else if ((rx_count / 50) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual char %0h last %b status %0d",
                 $time, out_char, last, status);
      end else begin
        want = expected_q.pop_front();
        compare_field("out_char", want.ch, out_char);
        compare_field("last", 8'(want.last), 8'(last));
        compare_field("status", 8'(want.status), 8'(status));
        compare_field("length", 8'(want.length), 8'(length));
        compare_field("cursor_pos", 8'(want.cursor), 8'(cursor_pos));
      end
      rx_count++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cleb_pkg.sv
rtl/cleb_ctrl.sv
rtl/cleb_dp.sv
rtl/cursor_line_edit_buffer_top.sv
bench/tb_cursor_line_edit_buffer_top.sv
